### src/pcx_pkg.sv
package pcx_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [8:0] PALETTE_LIMIT = 9'(PALETTE_ENTRIES);

	localparam logic [7:0] RUN_BASE = 8'd192;

	localparam logic [1:0] FUNC_PAL_WRITE = 2'd0;
	localparam logic [1:0] FUNC_DATA = 2'd1;
	localparam logic [1:0] FUNC_FRAME_START = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] byte_value;
		logic [7:0] pal_index;
		logic [7:0] pal_red;
		logic [7:0] pal_green;
		logic [7:0] pal_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       run_last;
		logic       frame_last;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic pal_write;
		logic frame_start;
		logic mark_finished;
		logic set_run;
		logic emit_begin;
		logic emit_step;
	} cmd_t;

	typedef struct packed {
		logic frame_finished;
		logic frame_full;
		logic expect_value;
		logic is_header;
		logic emit_last;
		logic out_free;
	} status_t;

endpackage

### src/pcx_ctrl.sv
module pcx_ctrl import pcx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] func,
	input  status_t    status,
	output logic       in_ready,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_next;
	logic   accept;
	logic   begins_emit;

	assign accept = in_valid && (state_q == ST_IDLE);

	always_comb begin
		begins_emit = 1'b0;
		if (accept && func == FUNC_DATA && !status.frame_finished && !status.frame_full) begin
			begins_emit = status.expect_value || !status.is_header;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (begins_emit) begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free && status.emit_last) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					unique case (func)
						FUNC_PAL_WRITE: cmd.pal_write = 1'b1;
						FUNC_FRAME_START: cmd.frame_start = 1'b1;
						FUNC_DATA: begin
							if (!status.frame_finished) begin
								if (status.frame_full) begin
									cmd.mark_finished = 1'b1;
								end else if (begins_emit) begin
									cmd.emit_begin = 1'b1;
								end else begin
									cmd.set_run = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_EMIT: begin
				cmd.emit_step = status.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

### src/pcx_dp.sv
module pcx_dp import pcx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	input  in_item_t    in_data,
	input  cmd_t        cmd,
	input  logic        out_ready,
	output status_t     status,
	output logic        out_valid,
	output out_item_t   out_data
);

	logic [23:0] pal_mem [PALETTE_ENTRIES];
	logic [23:0] rgb_q;
	logic        rgb_ok_q;
	logic [23:0] frame_pixels_q;
	logic [23:0] pixels_done_q;
	logic [5:0]  pending_run_q;
	logic        expect_value_q;
	logic        frame_finished_q;
	logic [5:0]  cnt_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        frame_end;
	logic        run_end;
	logic [23:0] pixels_next;
	logic        wr_in_range;
	logic        rd_in_range;

	assign wr_in_range = {1'b0, in_data.pal_index} < PALETTE_LIMIT;
	assign rd_in_range = {1'b0, in_data.byte_value} < PALETTE_LIMIT;
	assign pixels_next = pixels_done_q + 24'd1;
	assign frame_end = pixels_next == frame_pixels_q;
	assign run_end = (cnt_q == 6'd1) || frame_end;

	assign status.frame_finished = frame_finished_q;
	assign status.frame_full = pixels_done_q >= frame_pixels_q;
	assign status.expect_value = expect_value_q;
	assign status.is_header = in_data.byte_value > RUN_BASE;
	assign status.emit_last = run_end;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (cmd.pal_write && wr_in_range) begin
			pal_mem[in_data.pal_index[PAL_ADDR_W-1:0]] <=
				{in_data.pal_red, in_data.pal_green, in_data.pal_blue};
		end
		if (cmd.emit_begin) begin
			rgb_q <= pal_mem[in_data.byte_value[PAL_ADDR_W-1:0]];
			rgb_ok_q <= rd_in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_begin) begin
			cnt_q <= expect_value_q ? pending_run_q : 6'd1;
		end else if (cmd.emit_step) begin
			cnt_q <= cnt_q - 6'd1;
		end
		if (cmd.emit_step) begin
			out_q.red <= rgb_ok_q ? rgb_q[23:16] : 8'd0;
			out_q.green <= rgb_ok_q ? rgb_q[15:8] : 8'd0;
			out_q.blue <= rgb_ok_q ? rgb_q[7:0] : 8'd0;
			out_q.run_last <= run_end;
			out_q.frame_last <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= 24'd1;
			pixels_done_q <= '0;
			pending_run_q <= '0;
			expect_value_q <= 1'b0;
			frame_finished_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_pixels_q <= cfg_wdata;
			end
			if (cmd.frame_start) begin
				pixels_done_q <= '0;
				pending_run_q <= '0;
				expect_value_q <= 1'b0;
				frame_finished_q <= frame_pixels_q == 24'd0;
			end
			if (cmd.mark_finished) begin
				frame_finished_q <= 1'b1;
				pending_run_q <= '0;
				expect_value_q <= 1'b0;
			end
			if (cmd.set_run) begin
				pending_run_q <= 6'(in_data.byte_value - RUN_BASE);
				expect_value_q <= 1'b1;
			end
			if (cmd.emit_begin) begin
				pending_run_q <= '0;
				expect_value_q <= 1'b0;
			end
			if (cmd.emit_step) begin
				pixels_done_q <= pixels_next;
				if (frame_end) begin
					frame_finished_q <= 1'b1;
				end
			end
			if (cmd.emit_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_step_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> (!out_valid_q || out_ready))
		else $error("pixel produced while the output register is occupied");

	a_step_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> (cnt_q != 6'd0))
		else $error("pixel produced with an exhausted run count");

	a_frame_end_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_step && frame_end) |=> (frame_finished_q && out_q.run_last))
		else $error("frame end did not close the frame and the run");

	a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.frame_last) |-> out_q.run_last)
		else $error("last pixel of the frame is not marked as last of its run");

endmodule

### src/pcx_rle_palette_decoder.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      in_data    (in_item_t)
// out      output     out_valid / out_ready    out_data   (out_item_t)
// cfg      input      cfg_we                   cfg_wdata  (frame pixel count)
//
// A palette write, a frame start, a run header or an ignored byte leaves the controller
// idle. A byte that yields pixels first reads the palette into a register, then sends
// its pixels through the output register: one for a literal, n for a run of n pixels.
// Reset is asynchronous and active low; the palette holds no reset value.
// Output stalls hold the pixel sequencer, and the input waits until the run is sent.
module pcx_rle_palette_decoder import pcx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	cmd_t    cmd;
	status_t status;

	pcx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (in_data.func),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	pcx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_ready (out_ready),
		.status    (status),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

### sim/tb.sv
module tb;
	import pcx_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 70;

	typedef struct {
		bit          is_cfg;
		logic [23:0] cfg_value;
		in_item_t    item;
		int          n_typed;
		out_item_t   typed;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [23:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;

	pcx_rle_palette_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	logic [23:0] pal_mem [PALETTE_ENTRIES];
	bit          pal_written [PALETTE_ENTRIES];
	logic [7:0]  written_idx [$];
	logic [5:0]  run_pending = '0;
	bit          value_next = 1'b0;
	logic [23:0] px_done = '0;
	bit          frame_done = 1'b1;
	logic [23:0] frame_size = 24'd1;

	out_item_t   new_pixels [$];
	out_item_t   pixels_due [$];
	stim_row_t   directed [$];

	int pixel_errors = 0;
	int stall_cycles = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void put_pixels(logic [7:0] idx, int unsigned count);
		out_item_t   px;
		logic [23:0] rgb;
		int unsigned left;
		int unsigned n;
		rgb = (idx < PALETTE_ENTRIES) ? pal_mem[idx] : 24'd0;
		left = frame_size - px_done;
		n = (count < left) ? count : left;
		for (int unsigned k = 0; k < n; k++) begin
			px_done = px_done + 24'd1;
			px = {rgb, (k + 1 == n), (px_done == frame_size)};
			new_pixels.push_back(px);
		end
		if (px_done >= frame_size) begin
			frame_done = 1'b1;
			run_pending = '0;
			value_next = 1'b0;
		end
	endfunction

	function automatic void decode_item(in_item_t it);
		int unsigned count;
		case (it.func)
			FUNC_PAL_WRITE: begin
				if (it.pal_index < PALETTE_ENTRIES) begin
					if (!pal_written[it.pal_index]) begin
						written_idx.push_back(it.pal_index);
					end
					pal_written[it.pal_index] = 1'b1;
					pal_mem[it.pal_index] = {it.pal_red, it.pal_green, it.pal_blue};
				end
			end
			FUNC_FRAME_START: begin
				px_done = '0;
				run_pending = '0;
				value_next = 1'b0;
				frame_done = (frame_size == 24'd0);
			end
			FUNC_DATA: begin
				if (!frame_done) begin
					if (px_done >= frame_size) begin
						frame_done = 1'b1;
						run_pending = '0;
						value_next = 1'b0;
					end else if (value_next) begin
						count = run_pending;
						value_next = 1'b0;
						run_pending = '0;
						put_pixels(it.byte_value, count);
					end else if (it.byte_value > RUN_BASE) begin
						run_pending = 6'(it.byte_value - RUN_BASE);
						value_next = 1'b1;
					end else begin
						put_pixels(it.byte_value, 1);
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Mostly frame starts followed by literals and run pairs, with some noise.
	// A byte that would read the palette is steered onto an entry already written.
	function automatic in_item_t make_item();
		in_item_t    it;
		int unsigned pick;
		it.byte_value = 8'($urandom);
		it.pal_index = 8'($urandom);
		it.pal_red = 8'($urandom);
		it.pal_green = 8'($urandom);
		it.pal_blue = 8'($urandom);
		pick = $urandom_range(99);
		if (frame_done) begin
			if (pick < 60) it.func = FUNC_FRAME_START;
			else if (pick < 80) it.func = FUNC_PAL_WRITE;
			else if (pick < 95) it.func = FUNC_DATA;
			else it.func = FUNC_UNUSED;
		end else if (pick < 8) begin
			it.func = FUNC_PAL_WRITE;
		end else if (pick < 11) begin
			it.func = FUNC_FRAME_START;
		end else if (pick < 13) begin
			it.func = FUNC_UNUSED;
		end else begin
			it.func = FUNC_DATA;
			if (!value_next) begin
				if ($urandom_range(99) < 35) begin
					it.byte_value = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 193)) :
						8'($urandom_range(200, 193));
				end else begin
					it.byte_value = 8'($urandom_range(192));
				end
			end
		end
		if (it.func == FUNC_DATA && !frame_done && px_done < frame_size &&
			(value_next || it.byte_value <= RUN_BASE) && !pal_written[it.byte_value]) begin
			it.byte_value = written_idx[$urandom_range(written_idx.size() - 1)];
		end
		return it;
	endfunction

	function automatic void add_cfg(logic [23:0] v);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.cfg_value = v;
		directed.push_back(r);
	endfunction

	function automatic void add_item(logic [1:0] f, logic [7:0] bv, logic [7:0] idx,
		logic [23:0] rgb, int n_typed, logic [23:0] want_rgb, logic want_run, logic want_frame);
		stim_row_t r;
		r = '{default: '0};
		r.item.func = f;
		r.item.byte_value = bv;
		r.item.pal_index = idx;
		{r.item.pal_red, r.item.pal_green, r.item.pal_blue} = rgb;
		r.n_typed = n_typed;
		r.typed = {want_rgb, want_run, want_frame};
		directed.push_back(r);
	endfunction

	function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
		pixel_errors++;
		if (pixel_errors <= 10) begin
			$display("%s: expected rgb %h %h %h run_last %b frame_last %b, got rgb %h %h %h run_last %b frame_last %b",
				what, want.red, want.green, want.blue, want.run_last, want.frame_last,
				got.red, got.green, got.blue, got.run_last, got.frame_last);
		end
	endfunction

	task automatic send_item(in_item_t it, int n_typed, out_item_t typed);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_ready !== 1'b1);
		new_pixels.delete();
		decode_item(it);
		if (n_typed < 0) begin
			foreach (new_pixels[i]) pixels_due.push_back(new_pixels[i]);
		end else begin
			repeat (n_typed) pixels_due.push_back(typed);
		end
		@(negedge clk);
	endtask

	task automatic write_frame_size(logic [23:0] v);
		in_valid <= 1'b0;
		while (pixels_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		frame_size = v;
	endtask

	task automatic run_phase(logic [23:0] size, int s_idle, int r_stall, int n, bit hold);
		write_frame_size(size);
		sender_idle_pct = s_idle;
		recv_stall_pct = r_stall;
		hold_req = hold;
		repeat (n) send_item(make_item(), -1, '0);
	endtask

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : pixel_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixels_due.size() == 0) begin
				note_mismatch("pixel with nothing pending", '0, out_data);
			end else begin
				want = pixels_due.pop_front();
				if (out_data !== want) note_mismatch("pixel mismatch", want, out_data);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		add_item(FUNC_DATA, 8'h05, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_UNUSED, 8'hFF, 8'hFF, 24'hFFFFFF, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_PAL_WRITE, 8'h00, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_PAL_WRITE, 8'hFF, 8'hFF, 24'hFFFFFF, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_PAL_WRITE, 8'h00, 8'h5A, 24'h123456, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_PAL_WRITE, 8'h00, 8'hC0, 24'hA55AC3, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_FRAME_START, 8'h00, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'h00, 8'h00, 24'h000000, 1, 24'h000000, 1'b1, 1'b1);
		add_cfg(24'hFFFFFF);
		add_item(FUNC_FRAME_START, 8'h00, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'hC0, 8'h00, 24'h000000, 1, 24'hA55AC3, 1'b1, 1'b0);
		add_item(FUNC_DATA, 8'hC1, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'hFF, 8'h00, 24'h000000, 1, 24'hFFFFFF, 1'b1, 1'b0);
		add_item(FUNC_DATA, 8'hFF, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'h5A, 8'h00, 24'h000000, -1, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'hC3, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_FRAME_START, 8'h00, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'hC0, 8'h00, 24'h000000, 1, 24'hA55AC3, 1'b1, 1'b0);
		add_cfg(24'd5);
		add_item(FUNC_FRAME_START, 8'h00, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'h00, 8'h00, 24'h000000, -1, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'hC8, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'hFF, 8'h00, 24'h000000, -1, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'h00, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_cfg(24'd3);
		add_item(FUNC_FRAME_START, 8'h00, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'h5A, 8'h00, 24'h000000, -1, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'h5A, 8'h00, 24'h000000, -1, 24'h0, 1'b0, 1'b0);
		add_cfg(24'd1);
		add_item(FUNC_DATA, 8'h00, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_cfg(24'd0);
		add_item(FUNC_FRAME_START, 8'h00, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);
		add_item(FUNC_DATA, 8'hFF, 8'h00, 24'h000000, 0, 24'h0, 1'b0, 1'b0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg) write_frame_size(directed[i].cfg_value);
			else send_item(directed[i].item, directed[i].n_typed, directed[i].typed);
		end

		run_phase(24'd24, 0, 0, 50, 1'b0);
		run_phase(24'hFFFFFF, 68, 0, 45, 1'b0);
		run_phase(24'd7, 0, 68, 50, 1'b1);
		run_phase(24'd0, 37, 37, 15, 1'b0);
		run_phase(24'd40, 37, 37, 55, 1'b0);
		run_phase(24'd1, 0, 0, 30, 1'b0);
		run_phase(24'd100, 0, 68, 40, 1'b0);

		in_valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pixel_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
